// ===== hdl/stu_pkg.sv =====
`default_nettype none
package stu_pkg;

  localparam int KIND_W     = 5;
  localparam int POS_OUT_W  = 32;
  localparam int LEN_OUT_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int NUM_KW     = 7;

  typedef enum logic [KIND_W-1:0] {
    TK_EOF, TK_INT, TK_IDENT, TK_FN, TK_LET, TK_IF, TK_ELSE, TK_WHILE,
    TK_RETURN, TK_I32, TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COLON,
    TK_SEMI, TK_COMMA, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT,
    TK_ARROW, TK_ASSIGN, TK_EQEQ, TK_NEQ, TK_INVALID, TK_LT, TK_LE, TK_GT,
    TK_GE
  } tok_kind_t;

  localparam logic [63:0] KW_CODE [NUM_KW] = '{
    64'h666E, 64'h6C6574, 64'h6966, 64'h656C7365,
    64'h7768696C65, 64'h72657475726E, 64'h693332
  };

  localparam tok_kind_t KW_KIND [NUM_KW] = '{
    TK_FN, TK_LET, TK_IF, TK_ELSE, TK_WHILE, TK_RETURN, TK_I32
  };

  typedef struct packed {
    tok_kind_t            kind;
    logic [POS_OUT_W-1:0] line;
    logic [POS_OUT_W-1:0] column;
    logic [POS_OUT_W-1:0] offset;
    logic [LEN_OUT_W-1:0] length;
  } tok_t;

  // one accepted word yields up to two tokens; the first sits in tok0
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } qwr_t;

endpackage
`default_nettype wire

// ===== hdl/stu_if.sv =====
`default_nettype none
interface stu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface stu_out_if;
  logic                            valid;
  logic                            ready;
  logic [stu_pkg::KIND_W-1:0]      token_kind;
  logic [stu_pkg::POS_OUT_W-1:0]   start_line;
  logic [stu_pkg::POS_OUT_W-1:0]   start_column;
  logic [stu_pkg::POS_OUT_W-1:0]   start_offset;
  logic [stu_pkg::LEN_OUT_W-1:0]   token_length;
  logic                            last_of_item;

  modport source (output valid, token_kind, start_line, start_column, start_offset,
                  token_length, last_of_item, input ready);
  modport sink (input valid, token_kind, start_line, start_column, start_offset,
                token_length, last_of_item, output ready);
endinterface
`default_nettype wire

// ===== hdl/stu_front.sv =====
`default_nettype none
module stu_front #(
  parameter int POS_WIDTH     = 32,
  parameter int LEN_WIDTH     = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  stu_in_if.sink           in_chan,
  input  wire logic        q_full,
  output stu_pkg::qwr_t    q_wr
);
  import stu_pkg::*;

  localparam int PW = 8 * KEYWORD_CHARS;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_WORD, M_SLASH, M_COMMENT, M_MINUS, M_EQ, M_BANG, M_LT, M_GT
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [POS_WIDTH-1:0] cur_off_r, cur_off_nxt;
  logic [POS_WIDTH-1:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [POS_WIDTH-1:0] tok_off_r, tok_off_nxt;
  logic [LEN_WIDTH-1:0] tok_len_r, tok_len_nxt;
  logic [PW-1:0]        prefix_r, prefix_nxt;
  logic                 too_long_r, too_long_nxt;

  logic [7:0] c;
  logic       acc;
  logic       is_digit, is_alpha;
  mode_t      start_mode;
  logic       single_v;
  tok_kind_t  single_kind;
  logic       flush_v;
  tok_kind_t  flush_kind;
  logic [LEN_WIDTH-1:0] flush_len;
  tok_kind_t  word_kind;
  logic       pair_v, consumed;
  tok_kind_t  pair_kind;
  logic       a_v, b_v;
  tok_kind_t  a_kind, b_kind;
  logic [LEN_WIDTH-1:0] a_len, b_len;
  tok_t       a_tok, b_tok;

  function automatic logic [POS_WIDTH-1:0] pos_inc(input logic [POS_WIDTH-1:0] v);
    pos_inc = (&v) ? v : v + POS_WIDTH'(1);
  endfunction

  function automatic logic [LEN_WIDTH-1:0] len_inc(input logic [LEN_WIDTH-1:0] v);
    len_inc = (&v) ? v : v + LEN_WIDTH'(1);
  endfunction

  assign c             = in_chan.source_byte;
  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && !q_full;

  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = (c == "_") || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

  always_comb begin
    start_mode  = M_IDLE;
    single_v    = 1'b0;
    single_kind = TK_INVALID;
    if (is_digit) begin
      start_mode = M_NUM;
    end else if (is_alpha) begin
      start_mode = M_WORD;
    end else begin
      case (c)
        " ", "\n": single_v = 1'b0;
        "/": start_mode = M_SLASH;
        "-": start_mode = M_MINUS;
        "=": start_mode = M_EQ;
        "!": start_mode = M_BANG;
        "<": start_mode = M_LT;
        ">": start_mode = M_GT;
        "(": begin single_v = 1'b1; single_kind = TK_LPAREN;  end
        ")": begin single_v = 1'b1; single_kind = TK_RPAREN;  end
        "{": begin single_v = 1'b1; single_kind = TK_LBRACE;  end
        "}": begin single_v = 1'b1; single_kind = TK_RBRACE;  end
        ":": begin single_v = 1'b1; single_kind = TK_COLON;   end
        ";": begin single_v = 1'b1; single_kind = TK_SEMI;    end
        ",": begin single_v = 1'b1; single_kind = TK_COMMA;   end
        "+": begin single_v = 1'b1; single_kind = TK_PLUS;    end
        "*": begin single_v = 1'b1; single_kind = TK_STAR;    end
        "%": begin single_v = 1'b1; single_kind = TK_PERCENT; end
        default: begin single_v = 1'b1; single_kind = TK_INVALID; end
      endcase
    end
  end

  always_comb begin
    word_kind = TK_IDENT;
    if (!too_long_r) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (64'(prefix_r) == KW_CODE[i]) word_kind = KW_KIND[i];
      end
    end
  end

  always_comb begin
    flush_v    = 1'b1;
    flush_kind = TK_INVALID;
    flush_len  = LEN_WIDTH'(1);
    case (mode_r)
      M_NUM:   begin flush_kind = TK_INT;  flush_len = tok_len_r; end
      M_WORD:  begin flush_kind = word_kind; flush_len = tok_len_r; end
      M_SLASH: flush_kind = TK_SLASH;
      M_MINUS: flush_kind = TK_MINUS;
      M_EQ:    flush_kind = TK_ASSIGN;
      M_BANG:  flush_kind = TK_INVALID;
      M_LT:    flush_kind = TK_LT;
      M_GT:    flush_kind = TK_GT;
      default: flush_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    cur_off_nxt  = cur_off_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_off_nxt  = tok_off_r;
    tok_len_nxt  = tok_len_r;
    prefix_nxt   = prefix_r;
    too_long_nxt = too_long_r;
    pair_v       = 1'b0;
    pair_kind    = TK_ARROW;
    consumed     = 1'b0;
    a_v          = 1'b0;
    a_kind       = flush_kind;
    a_len        = flush_len;
    b_v          = 1'b0;
    b_kind       = TK_EOF;
    b_len        = '0;
    if (in_chan.end_of_source) begin
      a_v          = flush_v;
      b_v          = 1'b1;
      mode_nxt     = M_IDLE;
      cur_line_nxt = POS_WIDTH'(1);
      cur_col_nxt  = POS_WIDTH'(1);
      cur_off_nxt  = '0;
    end else begin
      cur_off_nxt = pos_inc(cur_off_r);
      if (c == "\n") begin
        cur_line_nxt = pos_inc(cur_line_r);
        cur_col_nxt  = POS_WIDTH'(1);
      end else begin
        cur_col_nxt = pos_inc(cur_col_r);
      end
      case (mode_r)
        M_NUM: begin
          if (is_digit) begin
            consumed    = 1'b1;
            tok_len_nxt = len_inc(tok_len_r);
          end
        end
        M_WORD: begin
          if (is_digit || is_alpha) begin
            consumed    = 1'b1;
            tok_len_nxt = len_inc(tok_len_r);
            if (tok_len_r < LEN_WIDTH'(KEYWORD_CHARS)) prefix_nxt = {prefix_r[PW-9:0], c};
            else too_long_nxt = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            consumed = 1'b1;
            mode_nxt = M_COMMENT;
          end
        end
        M_COMMENT: begin
          consumed = 1'b1;
          if (c == "\n") mode_nxt = M_IDLE;
        end
        M_MINUS: begin pair_v = (c == ">"); pair_kind = TK_ARROW; end
        M_EQ:    begin pair_v = (c == "="); pair_kind = TK_EQEQ;  end
        M_BANG:  begin pair_v = (c == "="); pair_kind = TK_NEQ;   end
        M_LT:    begin pair_v = (c == "="); pair_kind = TK_LE;    end
        M_GT:    begin pair_v = (c == "="); pair_kind = TK_GE;    end
        default: consumed = 1'b0;
      endcase
      if (pair_v) begin
        a_v      = 1'b1;
        a_kind   = pair_kind;
        a_len    = LEN_WIDTH'(2);
        mode_nxt = M_IDLE;
      end else if (!consumed) begin
        a_v          = flush_v;
        tok_line_nxt = cur_line_r;
        tok_col_nxt  = cur_col_r;
        tok_off_nxt  = cur_off_r;
        tok_len_nxt  = LEN_WIDTH'(1);
        mode_nxt     = start_mode;
        if (is_alpha) begin
          prefix_nxt   = PW'(c);
          too_long_nxt = 1'b0;
        end
        b_v    = single_v;
        b_kind = single_kind;
        b_len  = LEN_WIDTH'(1);
      end
    end
  end

  always_comb begin
    a_tok.kind   = a_kind;
    a_tok.line   = POS_OUT_W'(tok_line_r);
    a_tok.column = POS_OUT_W'(tok_col_r);
    a_tok.offset = POS_OUT_W'(tok_off_r);
    a_tok.length = LEN_OUT_W'(a_len);
    b_tok.kind   = b_kind;
    b_tok.line   = POS_OUT_W'(cur_line_r);
    b_tok.column = POS_OUT_W'(cur_col_r);
    b_tok.offset = POS_OUT_W'(cur_off_r);
    b_tok.length = LEN_OUT_W'(b_len);
    q_wr.push      = acc && (a_v || b_v);
    q_wr.data.tok0 = a_v ? a_tok : b_tok;
    q_wr.data.tok1 = b_tok;
    q_wr.data.two  = a_v && b_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      cur_line_r <= POS_WIDTH'(1);
      cur_col_r  <= POS_WIDTH'(1);
      cur_off_r  <= '0;
      tok_line_r <= POS_WIDTH'(1);
      tok_col_r  <= POS_WIDTH'(1);
      tok_off_r  <= '0;
      tok_len_r  <= '0;
      prefix_r   <= '0;
      too_long_r <= 1'b0;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_off_r  <= cur_off_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      tok_off_r  <= tok_off_nxt;
      tok_len_r  <= tok_len_nxt;
      prefix_r   <= prefix_nxt;
      too_long_r <= too_long_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/stu_queue.sv =====
`default_nettype none
module stu_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stu_pkg::qwr_t     q_wr,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output stu_pkg::bundle_t       head
);
  import stu_pkg::*;

  bundle_t                mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]        cnt_r, cnt_nxt;
  logic                   do_pop;

  assign full   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign head   = mem[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr.push && !do_pop) cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    else if (!q_wr.push && do_pop) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) mem[wr_ptr_r] <= q_wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/stu_back.sv =====
`default_nettype none
module stu_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              empty,
  input  wire stu_pkg::bundle_t  head,
  output logic                   pop,
  stu_out_if.source              out_chan
);
  import stu_pkg::*;

  tok_t  out_tok_r, out_tok_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  out_last_r, out_last_nxt;
  logic  idx_r, idx_nxt;
  logic  load;

  assign load = !empty && (!out_valid_r || out_chan.ready);

  always_comb begin
    out_tok_nxt   = out_tok_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_tok_nxt   = idx_r ? head.tok1 : head.tok0;
      if (head.two && !idx_r) begin
        out_last_nxt = 1'b0;
        idx_nxt      = 1'b1;
      end else begin
        out_last_nxt = 1'b1;
        idx_nxt      = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    out_tok_r  <= out_tok_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.token_kind   = out_tok_r.kind;
  assign out_chan.start_line   = out_tok_r.line;
  assign out_chan.start_column = out_tok_r.column;
  assign out_chan.start_offset = out_tok_r.offset;
  assign out_chan.token_length = out_tok_r.length;
  assign out_chan.last_of_item = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/source_tokenizer_unit.sv =====
// Source tokenizer: scans a source text one byte per word on in_chan and
// sends one word per token on out_chan (kind, start line/column/offset,
// length, last_of_item marking the final token caused by an input word).
// Setting end_of_source flushes a pending token, sends Eof and returns the
// position to line 1, column 1, offset 0.
// Throughput: one input word per cycle while the token queue is not full.
// A word can end one token and emit another (or a flush plus Eof); such
// words need two output words, which the four-entry token queue between
// the lexer and the output stage absorbs. A token is written into the
// queue at the edge that accepts the input word completing it, then moves
// to the output register, from which it is valid on out_chan.
// Stall: while out_chan.ready is low the output word holds; the queue keeps
// filling and in_chan.ready drops only when it is full.
// Reset (rst_n low, synchronous): lexer returns to idle at line 1, column 1,
// offset 0; queue and output register are emptied.
`default_nettype none
module source_tokenizer_unit #(
  parameter int POS_WIDTH     = 32,
  parameter int LEN_WIDTH     = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  stu_in_if.sink    in_chan,
  stu_out_if.source out_chan
);
  import stu_pkg::*;

  qwr_t    q_wr;
  bundle_t head;
  logic    q_full, q_empty, pop;

  stu_front #(
    .POS_WIDTH     (POS_WIDTH),
    .LEN_WIDTH     (LEN_WIDTH),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  stu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  stu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (q_empty),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ===== hdl/stu_checker.sv =====
`default_nettype none
module stu_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [stu_pkg::KIND_W-1:0]      token_kind,
  input wire logic [stu_pkg::LEN_OUT_W-1:0]   token_length,
  input wire logic                            last_of_item
);
  import stu_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
    $stable(token_length) && $stable(last_of_item))
    else $error("stalled output word changed");

  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind == TK_EOF |-> token_length == '0 && last_of_item)
    else $error("Eof token malformed");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind == TK_ARROW || token_kind == TK_EQEQ ||
    token_kind == TK_NEQ || token_kind == TK_LE || token_kind == TK_GE)
    |-> token_length == LEN_OUT_W'(2))
    else $error("two-character operator with wrong length");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind == TK_LPAREN || token_kind == TK_SEMI ||
    token_kind == TK_STAR || token_kind == TK_PERCENT || token_kind == TK_INVALID ||
    token_kind == TK_ASSIGN || token_kind == TK_LT || token_kind == TK_GT)
    |-> token_length == LEN_OUT_W'(1))
    else $error("single-character token with wrong length");

endmodule

bind source_tokenizer_unit stu_checker u_stu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .token_kind   (out_chan.token_kind),
  .token_length (out_chan.token_length),
  .last_of_item (out_chan.last_of_item)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import stu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 900;
  localparam int LONG_RUN       = 40;
  localparam int REPORT_MAX     = 10;
  localparam int KW_CHARS       = 6;
  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_SLASH, SCAN_COMMENT,
    SCAN_MINUS, SCAN_EQ, SCAN_BANG, SCAN_LT, SCAN_GT
  } scan_mode_t;

  typedef struct packed {
    tok_kind_t            kind;
    logic [POS_OUT_W-1:0] line;
    logic [POS_OUT_W-1:0] column;
    logic [POS_OUT_W-1:0] offset;
    logic [LEN_OUT_W-1:0] length;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;
    token_t     want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       src_valid = 1'b0;
  logic [7:0] src_byte = 8'h00;
  logic       src_eos = 1'b0;
  logic       rx_ready = 1'b0;

  stu_in_if  in_ch ();
  stu_out_if out_ch ();

  assign in_ch.valid         = src_valid;
  assign in_ch.source_byte   = src_byte;
  assign in_ch.end_of_source = src_eos;
  assign out_ch.ready        = rx_ready;

  source_tokenizer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // lexer state as predicted
  scan_mode_t  scan_mode;
  logic [31:0] at_line, at_col, at_off;
  logic [31:0] tk_line, tk_col, tk_off;
  logic [15:0] tk_len;
  logic [47:0] word_head;
  logic        word_long;
  token_t      step_out [2];
  int          step_n;

  token_t tokens_due [$];
  row_t   opening_rows [$];
  int     sent_cnt = 0;
  int     fail_cnt = 0;
  int     taken_cnt = 0;
  int     rx_cycle = 0;
  int     hold_left = 0;
  int     stall_left = 0;
  int     idle_cycles = 0;

  function automatic logic [31:0] pos_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [15:0] len_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [47:0] keyword_text(input int i);
    case (i)
      0:       return 48'("fn");
      1:       return 48'("let");
      2:       return 48'("if");
      3:       return 48'("else");
      4:       return 48'("while");
      5:       return 48'("return");
      default: return 48'("i32");
    endcase
  endfunction

  function automatic logic [15:0] op_text(input int i);
    case (i)
      0:       return 16'("(");
      1:       return 16'(")");
      2:       return 16'("{");
      3:       return 16'("}");
      4:       return 16'(":");
      5:       return 16'(";");
      6:       return 16'(",");
      7:       return 16'("+");
      8:       return 16'("-");
      9:       return 16'("*");
      10:      return 16'("/");
      11:      return 16'("%");
      12:      return 16'("=");
      13:      return 16'("!");
      14:      return 16'("<");
      15:      return 16'(">");
      16:      return "->";
      17:      return "==";
      18:      return "!=";
      19:      return "<=";
      default: return ">=";
    endcase
  endfunction

  function automatic void scan_reset();
    scan_mode = SCAN_IDLE;
    at_line   = 32'd1;
    at_col    = 32'd1;
    at_off    = 32'd0;
    tk_line   = 32'd1;
    tk_col    = 32'd1;
    tk_off    = 32'd0;
    tk_len    = 16'd0;
    word_head = 48'd0;
    word_long = 1'b0;
  endfunction

  function automatic void note_token(input tok_kind_t kind, input logic [15:0] len);
    token_t t;
    if (step_n >= 2) return;
    t.kind   = kind;
    t.line   = tk_line;
    t.column = tk_col;
    t.offset = tk_off;
    t.length = len;
    t.last   = 1'b0;
    step_out[step_n] = t;
    step_n++;
  endfunction

  function automatic tok_kind_t word_kind();
    if (!word_long)
      for (int i = 0; i < 7; i++)
        if (word_head == keyword_text(i)) return tok_kind_t'(TK_FN + i);
    return TK_IDENT;
  endfunction

  function automatic void flush_pending();
    case (scan_mode)
      SCAN_NUM:   note_token(TK_INT, tk_len);
      SCAN_WORD:  note_token(word_kind(), tk_len);
      SCAN_SLASH: note_token(TK_SLASH, 16'd1);
      SCAN_MINUS: note_token(TK_MINUS, 16'd1);
      SCAN_EQ:    note_token(TK_ASSIGN, 16'd1);
      SCAN_BANG:  note_token(TK_INVALID, 16'd1);
      SCAN_LT:    note_token(TK_LT, 16'd1);
      SCAN_GT:    note_token(TK_GT, 16'd1);
      default: ;
    endcase
    scan_mode = SCAN_IDLE;
  endfunction

  function automatic void start_token(input logic [7:0] c);
    tk_line = at_line;
    tk_col  = at_col;
    tk_off  = at_off;
    tk_len  = 16'd1;
    if (c == " " || c == NEWLINE) return;
    if (is_digit(c)) begin
      scan_mode = SCAN_NUM;
    end else if (is_alpha(c)) begin
      scan_mode = SCAN_WORD;
      word_head = {40'd0, c};
      word_long = 1'b0;
    end else begin
      case (c)
        "/":     scan_mode = SCAN_SLASH;
        "-":     scan_mode = SCAN_MINUS;
        "=":     scan_mode = SCAN_EQ;
        "!":     scan_mode = SCAN_BANG;
        "<":     scan_mode = SCAN_LT;
        ">":     scan_mode = SCAN_GT;
        "(":     note_token(TK_LPAREN, 16'd1);
        ")":     note_token(TK_RPAREN, 16'd1);
        "{":     note_token(TK_LBRACE, 16'd1);
        "}":     note_token(TK_RBRACE, 16'd1);
        ":":     note_token(TK_COLON, 16'd1);
        ";":     note_token(TK_SEMI, 16'd1);
        ",":     note_token(TK_COMMA, 16'd1);
        "+":     note_token(TK_PLUS, 16'd1);
        "*":     note_token(TK_STAR, 16'd1);
        "%":     note_token(TK_PERCENT, 16'd1);
        default: note_token(TK_INVALID, 16'd1);
      endcase
    end
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    tok_kind_t pair;
    bit        paired;
    pair   = TK_EOF;
    paired = 1'b0;
    case (scan_mode)
      SCAN_NUM: begin
        if (is_digit(c)) begin
          tk_len = len_inc(tk_len);
          return;
        end
      end
      SCAN_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (tk_len < KW_CHARS) word_head = {word_head[39:0], c};
          else word_long = 1'b1;
          tk_len = len_inc(tk_len);
          return;
        end
      end
      SCAN_SLASH: begin
        if (c == "/") begin
          scan_mode = SCAN_COMMENT;
          return;
        end
      end
      SCAN_COMMENT: begin
        if (c == NEWLINE) scan_mode = SCAN_IDLE;
        return;
      end
      SCAN_MINUS: if (c == ">") begin paired = 1'b1; pair = TK_ARROW; end
      SCAN_EQ:    if (c == "=") begin paired = 1'b1; pair = TK_EQEQ; end
      SCAN_BANG:  if (c == "=") begin paired = 1'b1; pair = TK_NEQ; end
      SCAN_LT:    if (c == "=") begin paired = 1'b1; pair = TK_LE; end
      SCAN_GT:    if (c == "=") begin paired = 1'b1; pair = TK_GE; end
      default: ;
    endcase
    if (paired) begin
      note_token(pair, 16'd2);
      scan_mode = SCAN_IDLE;
      return;
    end
    flush_pending();
    start_token(c);
  endfunction

  function automatic void lex_step(input logic [7:0] c, input logic eos);
    step_n = 0;
    if (eos) begin
      flush_pending();
      tk_line = at_line;
      tk_col  = at_col;
      tk_off  = at_off;
      note_token(TK_EOF, 16'd0);
      scan_reset();
    end else begin
      take_byte(c);
      at_off = pos_inc(at_off);
      if (c == NEWLINE) begin
        at_line = pos_inc(at_line);
        at_col  = 32'd1;
      end else begin
        at_col = pos_inc(at_col);
      end
    end
  endfunction

  function automatic int pick_gap(input int idx);
    int r;
    if (idx % 160 < 40) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (r == 52) return "_";
    return "0" + 8'(r - 53);
  endfunction

  task automatic add_row(input logic [7:0] ch, input logic eos, input logic typed,
                         input tok_kind_t kind, input int line, input int col,
                         input int off, input int len);
    row_t r;
    r.ch          = ch;
    r.eos         = eos;
    r.typed       = typed;
    r.want.kind   = kind;
    r.want.line   = 32'(line);
    r.want.column = 32'(col);
    r.want.offset = 32'(off);
    r.want.length = 16'(len);
    r.want.last   = 1'b1;
    opening_rows.push_back(r);
  endtask

  task automatic send_word(input logic [7:0] ch, input logic eos, input logic typed,
                           input token_t want);
    token_t t;
    int     gap;
    gap = pick_gap(sent_cnt);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte  <= ch;
    src_eos   <= eos;
    do @(posedge clk); while (!in_ch.ready);
    lex_step(ch, eos);
    if (typed) begin
      tokens_due.push_back(want);
    end else begin
      for (int k = 0; k < step_n; k++) begin
        t = step_out[k];
        t.last = (k == step_n - 1);
        tokens_due.push_back(t);
      end
    end
    sent_cnt++;
  endtask

  task automatic feed(input logic [7:0] ch, input logic eos);
    send_word(ch, eos, 1'b0, '0);
  endtask

  initial begin : stimulus
    int          k, n, pick, sep, rand_stop;
    logic [47:0] text;
    logic [15:0] op;
    scan_reset();
    add_row(8'h00,   1'b0, 1'b1, TK_INVALID, 1, 1, 0, 1);
    add_row(8'hFF,   1'b0, 1'b1, TK_INVALID, 1, 2, 1, 1);
    add_row(8'h09,   1'b0, 1'b1, TK_INVALID, 1, 3, 2, 1);
    add_row("&",     1'b0, 1'b1, TK_INVALID, 1, 4, 3, 1);
    add_row("!",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row(" ",     1'b0, 1'b1, TK_INVALID, 1, 5, 4, 1);
    add_row("%",     1'b0, 1'b1, TK_PERCENT, 1, 7, 6, 1);
    add_row("*",     1'b0, 1'b1, TK_STAR, 1, 8, 7, 1);
    add_row(NEWLINE, 1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("/",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("/",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("x",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row(NEWLINE, 1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("f",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("n",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("-",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row(">",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("/",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row(8'hA5,   1'b1, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row(8'h5A,   1'b1, 1'b1, TK_EOF, 1, 1, 0, 0);
    add_row("/",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row("/",     1'b0, 1'b0, TK_EOF, 0, 0, 0, 0);
    add_row(8'hFF,   1'b1, 1'b1, TK_EOF, 1, 3, 2, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      send_word(opening_rows[i].ch, opening_rows[i].eos, opening_rows[i].typed,
                opening_rows[i].want);

    // send one long integer
    for (k = 0; k < LONG_RUN; k++) feed("0" + 8'($urandom_range(0, 9)), 1'b0);
    feed(8'h00, 1'b1);

    rand_stop = sent_cnt + RANDOM_ITEMS;
    while (sent_cnt < rand_stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        case ($urandom_range(0, 4))
          0: begin
            text = keyword_text($urandom_range(0, 6));
            for (k = 5; k >= 0; k--)
              if (text[k*8 +: 8] != 8'h00) feed(text[k*8 +: 8], 1'b0);
          end
          1: begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (k = 0; k < n; k++) feed(word_char(k == 0), 1'b0);
          end
          2: begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) feed("0" + 8'($urandom_range(0, 9)), 1'b0);
          end
          3: begin
            op = op_text($urandom_range(0, 20));
            if (op[15:8] != 8'h00) feed(op[15:8], 1'b0);
            feed(op[7:0], 1'b0);
          end
          default: begin
            feed("/", 1'b0);
            feed("/", 1'b0);
            n = $urandom_range(0, 8);
            for (k = 0; k < n; k++) feed(8'($urandom_range(32, 126)), 1'b0);
            feed(NEWLINE, 1'b0);
          end
        endcase
        sep = $urandom_range(0, 19);
        if (sep < 8) feed(" ", 1'b0);
        else if (sep < 11) feed(NEWLINE, 1'b0);
      end else if (pick < 95) begin
        feed(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        feed(8'($urandom), 1'b1);
      end
    end
    src_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("PASS source_tokenizer_unit");
    else
      $display("FAIL source_tokenizer_unit");
    $finish;
  end

  always @(posedge clk) begin : receiver
    token_t seen, want;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_ch.valid && rx_ready) begin
        seen.kind   = tok_kind_t'(out_ch.token_kind);
        seen.line   = out_ch.start_line;
        seen.column = out_ch.start_column;
        seen.offset = out_ch.start_offset;
        seen.length = out_ch.token_length;
        seen.last   = out_ch.last_of_item;
        if (tokens_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("unexpected token %0d: kind %0d line %0d col %0d off %0d len %0d",
                     taken_cnt, seen.kind, seen.line, seen.column, seen.offset,
                     seen.length);
        end else begin
          want = tokens_due.pop_front();
          if (seen !== want) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display({"token %0d mismatch: want kind %0d line %0d col %0d off %0d ",
                        "len %0d last %0b, got kind %0d line %0d col %0d off %0d ",
                        "len %0d last %0b"},
                       taken_cnt, want.kind, want.line, want.column, want.offset,
                       want.length, want.last, seen.kind, seen.line, seen.column,
                       seen.offset, seen.length, seen.last);
          end
        end
        taken_cnt++;
        if (taken_cnt == 30 || taken_cnt == 250) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap(rx_cycle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (src_valid && in_ch.ready) || (out_ch.valid && rx_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL source_tokenizer_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== source_tokenizer_unit.f =====
hdl/stu_pkg.sv
hdl/stu_if.sv
hdl/stu_front.sv
hdl/stu_queue.sv
hdl/stu_back.sv
hdl/source_tokenizer_unit.sv
hdl/stu_checker.sv
tb/sv/tb_top.sv
